[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the per-ID counter delta block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, off while reset is low.
`define AST_SYNC(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen on a clock edge outside reset.
`define AST_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

[src/pcdt_pkg.sv]
// ----------------------------------------------------------------------------
// pcdt_pkg
// Field widths, result kind codes and the match unit result type.
// ----------------------------------------------------------------------------
package pcdt_pkg;

    localparam int TASK_ID_W = 16;
    localparam int COUNT_W   = 32;
    localparam int KIND_W    = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_DELTA    = 2'd0,
        KIND_BASELINE = 2'd1,
        KIND_NONE     = 2'd2
    } t_kind;

    // Answer of the shared compare / subtract unit for one slot
    typedef struct packed {
        logic               hit;
        logic [COUNT_W-1:0] delta;
    } t_match;

endpackage

[src/pcdt_ram.sv]
// ----------------------------------------------------------------------------
// pcdt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcdt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 24,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/pcdt_match.sv]
// ----------------------------------------------------------------------------
// pcdt_match
// Shared slot compare and wrapping counter subtract, used once per scan beat.
// ----------------------------------------------------------------------------
module pcdt_match
    import pcdt_pkg::*;
#(
    parameter int ID_W = 16
) (
    input  logic [ID_W-1:0]    i_key,
    input  logic [COUNT_W-1:0] i_count,
    input  logic               i_slot_valid,
    input  logic [ID_W-1:0]    i_slot_id,
    input  logic [COUNT_W-1:0] i_slot_count,
    output t_match             o_res
);

    always_comb begin
        o_res.hit   = i_slot_valid && (i_slot_id == i_key);
        // modulo 2^COUNT_W by construction
        o_res.delta = i_count - i_slot_count;
    end

endmodule

[src/per_id_counter_delta_table.sv]
// ----------------------------------------------------------------------------
// per_id_counter_delta_table
// Per-task run-time delta table: returns counter growth since last query.
// ----------------------------------------------------------------------------
// Each beat names a task and its cumulative run-time counter. A null ID or an
// absent task goes straight to ST_DONE with a kind NONE result. Otherwise the
// table RAM is scanned from slot 0, one slot per cycle through its single read
// port and the shared compare/subtract unit: a hit in slot k yields kind DELTA,
// a miss after the last slot yields kind BASELINE and takes the round-robin
// fill slot. Each result is registered in ST_DONE and then moved into the
// output register. The input is not ready during a scan; it is ready again in
// the cycle the result enters the output register, even while that result
// waits. A result still waiting in the output register holds the next one
// back until it is taken.
// Slot valid bits clear at reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module per_id_counter_delta_table
    import pcdt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 24,
    parameter int ID_BITS       = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // [15:0] task_id, [47:16] cumulative_count
    input  logic [0:0]  i_s_tuser,   // [0] task_present
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] run_time_delta
    output logic [1:0]  o_m_tuser    // [1:0] result_kind
);

    localparam int ID_W  = (ID_BITS < TASK_ID_W) ? ID_BITS : TASK_ID_W;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ENT_W = ID_W + COUNT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state                   r_state, n_state;
    logic [ID_W-1:0]          r_key, n_key;
    logic [COUNT_W-1:0]       r_count, n_count;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic                     r_issue, n_issue;
    logic                     r_pend, n_pend;
    logic [IDX_W-1:0]         r_pend_idx, n_pend_idx;
    logic [IDX_W-1:0]         r_fill, n_fill;
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic [COUNT_W-1:0]       r_res_delta, n_res_delta;
    t_kind                    r_res_kind, n_res_kind;
    logic                     r_out_valid, n_out_valid;
    logic [COUNT_W-1:0]       r_out_delta, n_out_delta;
    t_kind                    r_out_kind, n_out_kind;

    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic [ENT_W-1:0]         ram_wdata;
    logic [ENT_W-1:0]         ram_rdata;
    t_match                   match;

    logic                     s_fire, m_fire;
    logic [ID_W-1:0]          in_key;
    logic [COUNT_W-1:0]       in_count;

    assign s_fire   = i_s_tvalid && o_s_tready;
    assign m_fire   = r_out_valid && i_m_tready;
    assign in_key   = i_s_tdata[ID_W-1:0];
    assign in_count = i_s_tdata[TASK_ID_W +: COUNT_W];

    pcdt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    pcdt_match #(
        .ID_W (ID_W)
    ) u_match (
        .i_key        (r_key),
        .i_count      (r_count),
        .i_slot_valid (r_valid[r_pend_idx]),
        .i_slot_id    (ram_rdata[COUNT_W +: ID_W]),
        .i_slot_count (ram_rdata[COUNT_W-1:0]),
        .o_res        (match)
    );

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_count     = r_count;
        n_idx       = r_idx;
        n_issue     = r_issue;
        n_pend      = 1'b0;
        n_pend_idx  = r_pend_idx;
        n_fill      = r_fill;
        n_valid     = r_valid;
        n_res_delta = r_res_delta;
        n_res_kind  = r_res_kind;
        n_out_valid = r_out_valid;
        n_out_delta = r_out_delta;
        n_out_kind  = r_out_kind;
        ram_we      = 1'b0;
        ram_waddr   = r_pend_idx;
        ram_wdata   = {r_key, r_count};

        if (m_fire) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_fire) begin
                    n_key   = in_key;
                    n_count = in_count;
                    if (in_key == '0 || !i_s_tuser[0]) begin
                        n_res_delta = '0;
                        n_res_kind  = KIND_NONE;
                        n_state     = ST_DONE;
                    end else begin
                        n_idx   = '0;
                        n_issue = 1'b1;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // read slot r_idx now, compare slot r_pend_idx from last beat
                if (r_issue) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx;
                    if (r_idx == LAST_IDX) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                if (r_pend) begin
                    if (match.hit) begin
                        ram_we      = 1'b1;
                        n_res_delta = match.delta;
                        n_res_kind  = KIND_DELTA;
                        n_issue     = 1'b0;
                        n_state     = ST_DONE;
                    end else if (r_pend_idx == LAST_IDX) begin
                        ram_we            = 1'b1;
                        ram_waddr         = r_fill;
                        n_valid[r_fill]   = 1'b1;
                        n_fill            = (r_fill == LAST_IDX) ? '0 : r_fill + 1'b1;
                        n_res_delta       = '0;
                        n_res_kind        = KIND_BASELINE;
                        n_issue           = 1'b0;
                        n_state           = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_fire) begin
                    n_out_valid = 1'b1;
                    n_out_delta = r_res_delta;
                    n_out_kind  = r_res_kind;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issue     <= 1'b0;
            r_pend      <= 1'b0;
            r_fill      <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issue     <= n_issue;
            r_pend      <= n_pend;
            r_fill      <= n_fill;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_count     <= n_count;
        r_idx       <= n_idx;
        r_pend_idx  <= n_pend_idx;
        r_res_delta <= n_res_delta;
        r_res_kind  <= n_res_kind;
        r_out_delta <= n_out_delta;
        r_out_kind  <= n_out_kind;
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_delta;
    assign o_m_tuser  = r_out_kind;

endmodule

[src/pcdt_checker.sv]
// ----------------------------------------------------------------------------
// pcdt_checker
// Port-level checks for the per-ID counter delta table, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcdt_checker
    import pcdt_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [47:0] i_s_tdata,
    input logic [0:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    // stalled result beat holds
    `AST_SYNC(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "result beat changed while stalled")

    // one item in flight: not ready right after a beat is taken
    `AST_SYNC(a_one_in_flight, i_clk, i_rst_n, i_s_tvalid && o_s_tready |=> !o_s_tready, "input taken again during a lookup")

    `AST_NEVER(a_kind_code, i_clk, i_rst_n, o_m_tvalid && o_m_tuser != KIND_DELTA && o_m_tuser != KIND_BASELINE && o_m_tuser != KIND_NONE, "undefined result kind")

    // only a hit carries a nonzero delta
    `AST_SYNC(a_zero_delta, i_clk, i_rst_n, o_m_tvalid && o_m_tuser != KIND_DELTA |-> o_m_tdata == '0, "nonzero delta on baseline or null result")

endmodule

bind per_id_counter_delta_table pcdt_checker u_pcdt_checker (.*);

[tb/sv/delta_table_checker.sv]
// ----------------------------------------------------------------------------
// delta_table_checker
// Watches both stream channels, predicts each answer and compares it.
// ----------------------------------------------------------------------------
// Every input beat taken by the block runs through a local copy of the task
// table (slot IDs, last readings, round-robin fill slot), which yields the
// expected delta and kind. Output beats are matched in order against those
// expectations. Mismatches and unexpected beats are counted for the top.
// ----------------------------------------------------------------------------
module delta_table_checker
    import pcdt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 24,
    parameter int ID_BITS       = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [47:0] i_s_tdata,   // [15:0] task_id, [47:16] cumulative_count
    input  logic [0:0]  i_s_tuser,   // [0] task_present
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // [31:0] run_time_delta
    input  logic [1:0]  i_m_tuser,   // [1:0] result_kind
    output int          o_mismatch_count,
    output int          o_results_pending
);

    localparam logic [TASK_ID_W-1:0] ID_MASK =
        (ID_BITS >= TASK_ID_W) ? '1 : TASK_ID_W'((1 << ID_BITS) - 1);

    typedef struct packed {
        logic [COUNT_W-1:0] delta;
        t_kind              kind;
    } t_answer;

    logic [TASK_ID_W-1:0] slot_task    [TABLE_ENTRIES];
    logic [COUNT_W-1:0]   slot_reading [TABLE_ENTRIES];
    int                   fill_ptr;
    t_answer              expected_answers [$];
    int                   mismatches = 0;
    int                   pending    = 0;

    assign o_mismatch_count  = mismatches;
    assign o_results_pending = pending;

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: mismatch: %s", $time, what);
    endtask

    // Look up the task, update the table and queue the answer it must give
    task automatic account_query(input logic [TASK_ID_W-1:0] raw_id,
                                 input logic present,
                                 input logic [COUNT_W-1:0] reading);
        logic [TASK_ID_W-1:0] id;
        int                   hit_slot;
        t_answer              ans;
        id        = raw_id & ID_MASK;
        hit_slot  = -1;
        ans.delta = '0;
        if (id == '0 || !present) begin
            ans.kind = KIND_NONE;
        end else begin
            // first matching slot from index 0
            for (int k = 0; k < TABLE_ENTRIES; k++)
                if (hit_slot < 0 && slot_task[k] == id)
                    hit_slot = k;
            if (hit_slot >= 0) begin
                ans.delta              = reading - slot_reading[hit_slot];
                ans.kind               = KIND_DELTA;
                slot_reading[hit_slot] = reading;
            end else begin
                ans.kind               = KIND_BASELINE;
                slot_task[fill_ptr]    = id;
                slot_reading[fill_ptr] = reading;
                fill_ptr               = (fill_ptr + 1) % TABLE_ENTRIES;
            end
        end
        expected_answers.push_back(ans);
    endtask

    always @(posedge i_clk) begin : watch
        t_answer want;
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                slot_task[k]    = '0;
                slot_reading[k] = '0;
            end
            fill_ptr = 0;
            expected_answers.delete();
        end else begin
            // answers are checked before this edge's query is queued
            if (i_m_tvalid && i_m_tready) begin
                if (expected_answers.size() == 0) begin
                    note_mismatch($sformatf("unexpected beat delta=%h kind=%0d",
                                            i_m_tdata, i_m_tuser));
                end else begin
                    want = expected_answers.pop_front();
                    if (i_m_tdata !== want.delta || i_m_tuser !== want.kind)
                        note_mismatch($sformatf(
                            "delta exp %h got %h, kind exp %0d got %0d",
                            want.delta, i_m_tdata, want.kind, i_m_tuser));
                end
            end
            if (i_s_tvalid && i_s_tready)
                account_query(i_s_tdata[15:0], i_s_tuser[0], i_s_tdata[47:16]);
        end
        pending = expected_answers.size();
    end

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the per-task run-time delta table.
// ----------------------------------------------------------------------------
// A short directed sequence covers null IDs, absent tasks, the ID and counter
// extremes and counter wrap. A random part then queries a pool of tasks larger
// than the table (hits, misses, evictions), mixed with null, absent and random
// IDs. Both channels idle at random; the checker does all prediction.
// ----------------------------------------------------------------------------
module testbench;
    import pcdt_pkg::*;

    localparam int POOL_SIZE    = 32;
    localparam int RANDOM_ITEMS = 450;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata    = '0;   // [15:0] task_id, [47:16] cumulative_count
    logic [0:0]  s_tuser    = '0;   // [0] task_present
    logic        m_tvalid;
    logic        m_tready   = 1'b0;
    logic [31:0] m_tdata;           // [31:0] run_time_delta
    logic [1:0]  m_tuser;           // [1:0] result_kind
    int          mismatch_count;
    int          results_pending;
    bit          quiet      = 1'b0; // stretch with no idling on either side

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    per_id_counter_delta_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    delta_table_checker checker_inst (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_s_tvalid        (s_tvalid),
        .i_s_tready        (s_tready),
        .i_s_tdata         (s_tdata),
        .i_s_tuser         (s_tuser),
        .i_m_tvalid        (m_tvalid),
        .i_m_tready        (m_tready),
        .i_m_tdata         (m_tdata),
        .i_m_tuser         (m_tuser),
        .o_mismatch_count  (mismatch_count),
        .o_results_pending (results_pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(15, 45);
    endfunction

    // present one beat, hold it until taken, then idle for a random gap, possibly none
    task automatic send_query(input logic [TASK_ID_W-1:0] id,
                              input logic present,
                              input logic [COUNT_W-1:0] reading);
        int gap;
        s_tdata  = {reading, id};
        s_tuser  = present;
        s_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    initial begin : ready_gen
        int gap;
        forever begin
            m_tready = 1'b1;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    end

    initial begin : stimulus
        logic [TASK_ID_W-1:0] pool_id    [POOL_SIZE];
        logic [COUNT_W-1:0]   pool_count [POOL_SIZE];
        int                   span;
        int                   r;
        int                   k;
        bit                   fresh;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // null ID, with and without the present flag
        send_query(16'h0000, 1'b1, 32'hFFFF_FFFF);
        send_query(16'h0000, 1'b0, 32'h0000_0000);
        // absent task leaves the table alone
        send_query(16'hFFFF, 1'b0, 32'h1234_5678);
        send_query(16'hFFFF, 1'b1, 32'hFFFF_FFF0);
        // counter wraps between queries
        send_query(16'hFFFF, 1'b1, 32'h0000_0010);
        send_query(16'h0001, 1'b1, 32'h0000_0000);
        send_query(16'h0001, 1'b1, 32'hFFFF_FFFF);
        send_query(16'h0001, 1'b1, 32'hFFFF_FFFF);
        send_query(16'hFFFF, 1'b0, 32'hDEAD_BEEF);
        send_query(16'hFFFF, 1'b1, 32'h0000_0010);
        send_query(16'h8000, 1'b1, 32'hAAAA_AAAA);
        send_query(16'h5555, 1'b1, 32'h5555_5555);
        send_query(16'h8000, 1'b1, 32'h5555_5555);
        send_query(16'hAAAA, 1'b1, 32'h8000_0000);
        send_query(16'h5555, 1'b1, 32'hAAAA_AAAA);

        // distinct nonzero task IDs; more of them than the table holds
        for (int i = 0; i < POOL_SIZE; i++) begin
            do begin
                pool_id[i] = TASK_ID_W'($urandom_range(1, 65535));
                fresh      = 1'b1;
                for (int j = 0; j < i; j++)
                    if (pool_id[j] == pool_id[i])
                        fresh = 1'b0;
            end while (!fresh);
            pool_count[i] = $urandom;
        end

        span = POOL_SIZE;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                quiet = ($urandom_range(0, 3) == 0);
                // a narrow span mostly hits, the full span keeps evicting
                span  = $urandom_range(0, 1) ? 8 : POOL_SIZE;
            end
            r = $urandom_range(0, 99);
            k = $urandom_range(0, span - 1);
            if (r < 70) begin
                case ($urandom_range(0, 9))
                    0:       pool_count[k] = pool_count[k] + $urandom;
                    1:       ;
                    default: pool_count[k] = pool_count[k] + $urandom_range(1, 5000);
                endcase
                send_query(pool_id[k], 1'b1, pool_count[k]);
            end else if (r < 80) begin
                send_query(TASK_ID_W'($urandom_range(0, 65535)),
                           1'($urandom_range(0, 1)), $urandom);
            end else if (r < 88) begin
                send_query(16'h0000, 1'($urandom_range(0, 1)), $urandom);
            end else begin
                send_query(pool_id[k], 1'b0, $urandom);
            end
        end
        s_tvalid = 1'b0;
        quiet    = 1'b0;

        while (results_pending != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
